// ===== rtl/exact_symbol_pattern_matcher_defines.svh =====
// assertion macros for the exact symbol pattern matcher
// used by the top level only, needs a signal named clock and one named reset in scope
`ifndef EXACT_SYMBOL_PATTERN_MATCHER_DEFINES_SVH
`define EXACT_SYMBOL_PATTERN_MATCHER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ESP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("esp assertion failed");

// next-cycle implication, checked outside reset
`define ESP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("esp assertion failed");

`endif

// ===== rtl/esp_pkg.sv =====
// shared constants and types for the exact symbol pattern matcher
// no dependencies
package esp_pkg;

   // capacities
   localparam int MaxPattern = 32;
   localparam int MaxRead    = 65536;

   // field widths
   localparam int SymW = 4;
   localparam int PosW = 16;

   // derived widths
   localparam int PatCountW  = $clog2(MaxPattern + 1);
   localparam int ReadCountW = $clog2(MaxRead + 1);
   localparam int DiffW      = (ReadCountW > PosW) ? ReadCountW : PosW;

   typedef logic [SymW-1:0]       sym_type;
   typedef logic [PosW-1:0]       pos_type;
   typedef logic [PatCountW-1:0]  pat_count_type;
   typedef logic [ReadCountW-1:0] read_count_type;

   // per-cycle controls broadcast to every cell
   typedef struct packed {
      logic pat_load;    // shift a pattern symbol into the chain
      logic read_shift;  // shift a read symbol into the window
   } cell_ctrl_type;

endpackage

// ===== rtl/esp_if.sv =====
// request and response channels of the exact symbol pattern matcher
// depends on esp_pkg
interface esp_req_if;
   logic            valid;
   logic            ready;
   logic            action;
   esp_pkg::sym_type symbol;
   logic            last;

   modport source (output valid, output action, output symbol, output last, input ready);
   modport sink   (input valid, input action, input symbol, input last, output ready);
endinterface

interface esp_rsp_if;
   logic            valid;
   logic            ready;
   esp_pkg::pos_type position;
   logic            is_match;
   logic            done_res;
   logic            found_any;
   logic            overflow;

   modport source (output valid, output position, output is_match, output done_res,
                   output found_any, output overflow, input ready);
   modport sink   (input valid, input position, input is_match, input done_res,
                   input found_any, input overflow, output ready);
endinterface

// ===== rtl/esp_cell.sv =====
// one cell of the matching chain: a pattern symbol, its used bit and a window symbol
// depends on esp_pkg
module esp_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  esp_pkg::cell_ctrl_type ctrl,
   input  esp_pkg::sym_type      pat_prev,
   input  logic                  used_prev,
   input  esp_pkg::sym_type      win_prev,
   output esp_pkg::sym_type      pat_out,
   output logic                  used_out,
   output esp_pkg::sym_type      win_out,
   output logic                  hit_out
);
   import esp_pkg::*;

   sym_type pat_ff;
   sym_type win_ff;
   logic    used_ff;

   // pattern symbol, shifted along on each load
   always_ff @(posedge clock) begin
      if (ctrl.pat_load) begin
         pat_ff <= pat_prev;
      end
   end

   // used bit marks cells that hold a symbol of the current pattern
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (ctrl.pat_load) begin
         used_ff <= used_prev;
      end
   end

   // read window symbol, shifted along on each read transfer
   always_ff @(posedge clock) begin
      if (ctrl.read_shift) begin
         win_ff <= win_prev;
      end
   end

   // compare against the window value that this transfer moves in
   assign hit_out  = !used_ff || (win_prev == pat_ff);
   assign pat_out  = pat_ff;
   assign used_out = used_ff;
   assign win_out  = win_ff;

endmodule

// ===== rtl/exact_symbol_pattern_matcher.sv =====
// top level of the exact symbol pattern matcher: control, cell chain, response register
// depends on esp_pkg, esp_if, esp_cell and exact_symbol_pattern_matcher_defines.svh
// a result is registered and shown in the cycle after the read symbol that causes it
// throughput: one symbol per cycle while req ready is high, all pattern cells compare in parallel in that cycle
// the response register stalls input only while a result waits and rsp ready is low
// reset (synchronous, active high) empties the pattern, closes it and clears the read state
// pattern and window symbols are not reset; only cells marked used are compared
module exact_symbol_pattern_matcher (
   input logic  clock,
   input logic  reset,
   esp_req_if.sink   req_if,
   esp_rsp_if.source rsp_if
);
   import esp_pkg::*;

`include "exact_symbol_pattern_matcher_defines.svh"

   // control state
   pat_count_type  pat_count_ff, pat_count_in;
   logic           pat_closed_ff, pat_closed_in;
   logic           pat_ovf_ff, pat_ovf_in;
   read_count_type read_count_ff, read_count_in;
   logic           found_ff, found_in;
   logic           read_ovf_ff, read_ovf_in;

   // response register
   logic    rsp_valid_ff;
   pos_type rsp_pos_ff;
   logic    rsp_match_ff, rsp_done_ff, rsp_found_ff, rsp_ovf_ff;

   // chain links
   cell_ctrl_type             ctrl;
   sym_type [MaxPattern-1:0]  pat_link;
   logic    [MaxPattern-1:0]  used_link;
   sym_type [MaxPattern-1:0]  win_link;
   sym_type [MaxPattern-1:0]  pat_q;
   logic    [MaxPattern-1:0]  used_q;
   sym_type [MaxPattern-1:0]  win_q;
   logic    [MaxPattern-1:0]  cell_hit;

   logic           accept, pat_xfer, read_xfer, new_pat;
   pat_count_type  pat_base;
   logic           pat_room, read_room, read_ovf_next, hit, emit;
   read_count_type read_count_next;
   logic [DiffW-1:0] pos_diff;

   // transfer decode
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept    = req_if.valid && req_if.ready;
   assign pat_xfer  = accept && !req_if.action;
   assign read_xfer = accept && req_if.action;
   assign new_pat   = pat_xfer && pat_closed_ff;

   // pattern side
   assign pat_base = new_pat ? '0 : pat_count_ff;
   assign pat_room = pat_base < PatCountW'(MaxPattern);
   assign ctrl.pat_load   = pat_xfer && pat_room;
   assign ctrl.read_shift = read_xfer;

   always_comb begin
      pat_count_in  = pat_count_ff;
      pat_ovf_in    = pat_ovf_ff;
      pat_closed_in = pat_closed_ff;
      if (pat_xfer) begin
         pat_closed_in = req_if.last;
         if (pat_room) begin
            pat_count_in = pat_base + PatCountW'(1);
            pat_ovf_in   = new_pat ? 1'b0 : pat_ovf_ff;
         end else begin
            pat_count_in = pat_base;
            pat_ovf_in   = 1'b1;
         end
      end
   end

   // cell chain
   genvar gi;
   generate
      for (gi = 0; gi < MaxPattern; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            assign pat_link[gi]  = req_if.symbol;
            assign used_link[gi] = 1'b1;
            assign win_link[gi]  = req_if.symbol;
         end else begin : g_body
            assign pat_link[gi]  = pat_q[gi-1];
            assign used_link[gi] = used_q[gi-1] && !new_pat;
            assign win_link[gi]  = win_q[gi-1];
         end
         esp_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .pat_prev  (pat_link[gi]),
            .used_prev (used_link[gi]),
            .win_prev  (win_link[gi]),
            .pat_out   (pat_q[gi]),
            .used_out  (used_q[gi]),
            .win_out   (win_q[gi]),
            .hit_out   (cell_hit[gi])
         );
      end
   endgenerate

   // read side: count, overflow and match decision
   assign read_room       = read_count_ff < ReadCountW'(MaxRead);
   assign read_count_next = read_room ? read_count_ff + ReadCountW'(1) : read_count_ff;
   assign read_ovf_next   = read_ovf_ff || !read_room;
   assign hit = read_xfer && pat_closed_ff && !pat_ovf_ff && !read_ovf_next
                && (pat_count_ff != '0)
                && (read_count_next >= ReadCountW'(pat_count_ff))
                && (&cell_hit);
   assign pos_diff = DiffW'(read_count_next) - DiffW'(pat_count_ff);
   assign emit     = read_xfer && (hit || req_if.last);

   always_comb begin
      read_count_in = read_count_ff;
      found_in      = found_ff;
      read_ovf_in   = read_ovf_ff;
      if (read_xfer) begin
         if (req_if.last) begin
            read_count_in = '0;
            found_in      = 1'b0;
            read_ovf_in   = 1'b0;
         end else begin
            read_count_in = read_count_next;
            found_in      = found_ff || hit;
            read_ovf_in   = read_ovf_next;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_count_ff  <= '0;
         pat_closed_ff <= 1'b1;
         pat_ovf_ff    <= 1'b0;
         read_count_ff <= '0;
         found_ff      <= 1'b0;
         read_ovf_ff   <= 1'b0;
      end else begin
         pat_count_ff  <= pat_count_in;
         pat_closed_ff <= pat_closed_in;
         pat_ovf_ff    <= pat_ovf_in;
         read_count_ff <= read_count_in;
         found_ff      <= found_in;
         read_ovf_ff   <= read_ovf_in;
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_pos_ff   <= hit ? pos_diff[PosW-1:0] : '0;
         rsp_match_ff <= hit;
         rsp_done_ff  <= req_if.last;
         rsp_found_ff <= found_ff || hit;
         rsp_ovf_ff   <= pat_ovf_ff || read_ovf_next;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.position  = rsp_pos_ff;
   assign rsp_if.is_match  = rsp_match_ff;
   assign rsp_if.done_res  = rsp_done_ff;
   assign rsp_if.found_any = rsp_found_ff;
   assign rsp_if.overflow  = rsp_ovf_ff;

   // checks
   `ESP_ASSERT_SAME(a_match_sets_found, rsp_valid_ff && rsp_match_ff, rsp_found_ff && !rsp_ovf_ff)
   `ESP_ASSERT_SAME(a_no_match_zero_pos, rsp_valid_ff && !rsp_match_ff, rsp_pos_ff == '0)
   `ESP_ASSERT_NEXT(a_last_clears_read, read_xfer && req_if.last, read_count_ff == '0 && !found_ff)
   `ESP_ASSERT_SAME(a_pat_count_bound, 1'b1, pat_count_ff <= PatCountW'(MaxPattern))

endmodule
